// File: sv/mcvp_pkg.sv
// Shared types and constants for the multi-channel velocity PID core.
// No dependencies.
package mcvp_pkg;

    localparam int GAIN_W    = 20;
    localparam int REG_W     = 3 * GAIN_W;
    localparam int NUM_REGS  = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CH_IN_W   = 2;
    localparam int SPEED_W   = 16;
    localparam int DRIVE_W   = 16;
    localparam int ERR_W     = SPEED_W + 1;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int INTEG_W   = 11;
    localparam int P_KP_W    = GAIN_W + 1 + ERR_W;
    localparam int P_KD_W    = GAIN_W + 1 + DIFF_W;
    localparam int P_KI_W    = GAIN_W + 1 + INTEG_W;
    localparam int SUM_W     = 41;

    // kp = 7.5, ki ~ 0.005, kd ~ 0.025 in Q4.16
    localparam logic [REG_W-1:0] GAIN_RESET = 60'd1801000390721536;

    typedef struct packed {
        logic [GAIN_W-1:0] kd;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kp;
    } t_gains;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic signed [ERR_W-1:0]   prev_err;
        logic signed [INTEG_W-1:0] integ;
    } t_chan_state;

    typedef struct packed {
        t_chan_state nxt;
        logic        sat;
    } t_calc_res;

endpackage

// File: sv/mcvp_gain_regs.sv
// Per-channel packed gain registers with a plain write port and one read port.
// Depends on mcvp_pkg.
module mcvp_gain_regs import mcvp_pkg::*; #(
    parameter int CHANNELS = 4,
    parameter int CH_W     = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data,
    input  logic [CH_W-1:0]      i_rd_idx,
    output t_gains               o_rd_gains
);

    t_gains r_gains [CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_gains[i] <= t_gains'(GAIN_RESET);
            end
        end else if (i_cfg_we && i_cfg_idx < CFG_IDX_W'(NUM_REGS)
                     && i_cfg_idx < CFG_IDX_W'(CHANNELS)) begin
            r_gains[i_cfg_idx[CH_W-1:0]] <= t_gains'(i_cfg_data);
        end
    end

    assign o_rd_gains = r_gains[i_rd_idx];

endmodule

// File: sv/mcvp_calc.sv
// PID update arithmetic: error, clamped integral, fixed-point increment,
// truncation toward zero and 16-bit saturation. Depends on mcvp_pkg.
module mcvp_calc import mcvp_pkg::*; #(
    parameter int INTEGRAL_LIMIT = 1000,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  t_gains                     i_gains,
    input  logic signed [SPEED_W-1:0]  i_target_speed,
    input  logic signed [SPEED_W-1:0]  i_measured_speed,
    input  t_chan_state                i_state,
    output t_calc_res                  o_res
);

    localparam logic signed [DIFF_W-1:0] LIM_POS = DIFF_W'(INTEGRAL_LIMIT);
    localparam logic signed [DIFF_W-1:0] LIM_NEG = -LIM_POS;
    localparam logic signed [SUM_W-1:0]  BIAS    =
        SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
    localparam logic signed [SUM_W-1:0]  SAT_HI  = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0]  SAT_LO  = -(SUM_W'(32768));

    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] integ_sum;
    logic signed [DIFF_W-1:0] integ_clamp;
    logic signed [DIFF_W-1:0] d_err;
    logic signed [GAIN_W:0]   kp_s;
    logic signed [GAIN_W:0]   ki_s;
    logic signed [GAIN_W:0]   kd_s;
    logic signed [P_KP_W-1:0] p_kp;
    logic signed [P_KD_W-1:0] p_kd;
    logic signed [P_KI_W-1:0] p_ki;
    logic signed [SUM_W-1:0]  total;
    logic signed [SUM_W-1:0]  q;

    always_comb begin
        err       = ERR_W'(i_target_speed) - ERR_W'(i_measured_speed);
        integ_sum = DIFF_W'(i_state.integ) + DIFF_W'(err);
        if (integ_sum > LIM_POS) begin
            integ_clamp = LIM_POS;
        end else if (integ_sum < LIM_NEG) begin
            integ_clamp = LIM_NEG;
        end else begin
            integ_clamp = integ_sum;
        end
        d_err = DIFF_W'(err) - DIFF_W'(i_state.prev_err);

        kp_s = signed'({1'b0, i_gains.kp});
        ki_s = signed'({1'b0, i_gains.ki});
        kd_s = signed'({1'b0, i_gains.kd});
        p_kp = P_KP_W'(kp_s) * P_KP_W'(err);
        p_kd = P_KD_W'(kd_s) * P_KD_W'(d_err);
        p_ki = P_KI_W'(ki_s) * P_KI_W'(integ_clamp);

        total = (SUM_W'(i_state.drive) <<< GAIN_FRAC_BITS)
              + SUM_W'(p_kp) + SUM_W'(p_kd) + SUM_W'(p_ki);
        // round toward zero
        q = (total + (total[SUM_W-1] ? BIAS : SUM_W'(0))) >>> GAIN_FRAC_BITS;

        if (q > SAT_HI) begin
            o_res.nxt.drive = DRIVE_W'(SAT_HI);
            o_res.sat       = 1'b1;
        end else if (q < SAT_LO) begin
            o_res.nxt.drive = DRIVE_W'(SAT_LO);
            o_res.sat       = 1'b1;
        end else begin
            o_res.nxt.drive = q[DRIVE_W-1:0];
            o_res.sat       = 1'b0;
        end
        o_res.nxt.prev_err = err;
        o_res.nxt.integ    = integ_clamp[INTEG_W-1:0];
    end

endmodule

// File: sv/multi_channel_velocity_pid.sv
// An accepted transaction waits in the input register, then moves to the result register when it is empty or read.
// Throughput: one transaction per cycle while the result is not stalled, also back to back on the same channel;
// the channel state is read, updated and written back in the same cycle.
// Reset (synchronous, active low) clears drive, previous error and integral of
// every channel and loads the default gains; no clearing pass is needed.
// Depends on mcvp_pkg, mcvp_gain_regs and mcvp_calc.
module multi_channel_velocity_pid_core import mcvp_pkg::*; #(
    parameter int CHANNELS       = 4,
    parameter int INTEGRAL_LIMIT = 1000,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [REG_W-1:0]           i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [CH_IN_W-1:0]         i_channel,
    input  logic signed [SPEED_W-1:0]  i_target_speed,
    input  logic signed [SPEED_W-1:0]  i_measured_speed,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [CH_IN_W-1:0]         o_out_channel,
    output logic signed [DRIVE_W-1:0]  o_drive,
    output logic                       o_drive_saturated
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                      r_in_vld;
    logic [CH_IN_W-1:0]        r_in_ch;
    logic signed [SPEED_W-1:0] r_in_tgt;
    logic signed [SPEED_W-1:0] r_in_meas;

    logic                      r_out_vld;
    logic [CH_IN_W-1:0]        r_out_ch;
    logic signed [DRIVE_W-1:0] r_out_drive;
    logic                      r_out_sat;

    t_chan_state r_state [CHANNELS];

    logic        move;
    logic        ch_ok;
    logic [CH_W-1:0] ch_idx;
    t_gains      sel_gains;
    t_chan_state sel_state;
    t_calc_res   calc;

    assign ch_ok     = {1'b0, r_in_ch} < (CH_IN_W + 1)'(CHANNELS);
    assign ch_idx    = r_in_ch[CH_W-1:0];
    assign move      = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready   = !r_in_vld || move;
    assign sel_state = r_state[ch_idx];

    mcvp_gain_regs #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_gain_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rd_idx   (ch_idx),
        .o_rd_gains (sel_gains)
    );

    mcvp_calc #(
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_calc (
        .i_gains          (sel_gains),
        .i_target_speed   (r_in_tgt),
        .i_measured_speed (r_in_meas),
        .i_state          (sel_state),
        .o_res            (calc)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_ch   <= i_channel;
            r_in_tgt  <= i_target_speed;
            r_in_meas <= i_measured_speed;
        end
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_state[i] <= '0;
            end
        end else if (move && ch_ok) begin
            r_state[ch_idx] <= calc.nxt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (move) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_ch    <= r_in_ch;
            r_out_drive <= ch_ok ? calc.nxt.drive : '0;
            r_out_sat   <= ch_ok && calc.sat;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_out_channel     = r_out_ch;
    assign o_drive           = r_out_drive;
    assign o_drive_saturated = r_out_sat;

    a_integ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && ch_ok |-> (calc.nxt.integ <= INTEG_W'(INTEGRAL_LIMIT))
                       && (calc.nxt.integ >= -(INTEG_W'(INTEGRAL_LIMIT))))
        else $error("integral left its clamp range");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_sat |-> (r_out_drive == 16'sh7fff)
                                || (r_out_drive == 16'sh8000))
        else $error("saturation flag without clipped drive");

    a_move_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> r_out_vld && (r_out_ch == $past(r_in_ch)))
        else $error("transaction lost between input and result register");

    a_free_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> o_ready)
        else $error("input stalled while result register empty");

endmodule
